[src/cse_pkg.sv]
// Shared types, constants and helpers for the C string escape encoder.
`timescale 1ns / 1ps

package cse_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_DIGIT0    = 8'h30;
    localparam logic [7:0] CH_HEX_ALPHA = 8'h37;   // 'A' - 10
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TILDE     = 8'h7E;

    // body of one input word as the back end writes it
    typedef enum logic [1:0] {
        BODY_NONE = 2'd0,   // no byte written
        BODY_RAW  = 2'd1,   // byte as it is
        BODY_ESC  = 2'd2,   // backslash, then code letter
        BODY_HEX  = 2'd3    // backslash, x, two hex digits
    } t_body_kind;

    typedef struct packed {
        logic       open_q;
        t_body_kind kind;
        logic [7:0] data;     // raw byte, code letter or hex value
        logic       close_q;
        logic       last;
    } t_entry;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] ext;
        ext = {4'h0, v};
        return (v < 4'd10) ? (CH_DIGIT0 + ext) : (CH_HEX_ALPHA + ext);
    endfunction

endpackage

[src/cse_front.sv]
// Front end: accepts input words, tracks string state, classifies each byte.
`timescale 1ns / 1ps

module cse_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    input  logic          i_no_byte,
    input  logic          i_last,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_data,
    input  logic          i_q_full,
    output logic          o_push,
    output cse_pkg::t_entry o_entry
);
    import cse_pkg::*;

    logic       r_wrap_quotes;
    logic       r_at_start;
    logic [1:0] r_raw_left;
    logic       r_stopped;
    logic       n_at_start;
    logic [1:0] n_raw_left;
    logic       n_stopped;

    logic       accept;
    t_body_kind kind;
    logic [7:0] data;
    logic       body_empty;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;

    always_comb begin
        kind       = BODY_NONE;
        data       = i_byte;
        n_raw_left = r_raw_left;
        n_stopped  = r_stopped;
        if (!i_no_byte && !r_stopped) begin
            if (r_raw_left != 2'd0) begin
                kind       = BODY_RAW;
                n_raw_left = r_raw_left - 2'd1;
            end else if (i_byte[7:5] == 3'b110) begin
                kind       = BODY_RAW;
                n_raw_left = 2'd1;
            end else if (i_byte[7:4] == 4'b1110) begin
                kind       = BODY_RAW;
                n_raw_left = 2'd2;
            end else if (i_byte[7:3] == 5'b11110) begin
                kind       = BODY_RAW;
                n_raw_left = 2'd3;
            end else if (i_byte >= CH_SPACE && i_byte <= CH_TILDE
                         && i_byte != CH_QUOTE && i_byte != CH_BACKSLASH) begin
                kind = BODY_RAW;
            end else begin
                kind = BODY_ESC;
                case (i_byte)
                    CH_QUOTE:     data = CH_QUOTE;
                    CH_BACKSLASH: data = CH_BACKSLASH;
                    8'h07:        data = 8'h61;   // a
                    8'h08:        data = 8'h62;   // b
                    8'h09:        data = 8'h74;   // t
                    8'h0A:        data = 8'h6E;   // n
                    8'h0B:        data = 8'h76;   // v
                    8'h0C:        data = 8'h66;   // f
                    8'h0D:        data = 8'h72;   // r
                    default: begin
                        kind = BODY_HEX;
                        if (i_byte == 8'h00) begin
                            n_stopped = 1'b1;
                        end
                    end
                endcase
            end
        end
        n_at_start = i_last ? 1'b1 : 1'b0;
        if (i_last) begin
            n_raw_left = 2'd0;
            n_stopped  = 1'b0;
        end
    end

    assign o_entry.open_q  = r_at_start && r_wrap_quotes;
    assign o_entry.kind    = kind;
    assign o_entry.data    = data;
    assign o_entry.close_q = i_last && r_wrap_quotes;
    assign o_entry.last    = i_last;

    assign body_empty = (kind == BODY_NONE) && !o_entry.open_q && !o_entry.close_q;
    assign o_push     = accept && !body_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_quotes <= 1'b1;
            r_at_start    <= 1'b1;
            r_raw_left    <= 2'd0;
            r_stopped     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_wrap_quotes <= i_cfg_data;
            end
            if (accept) begin
                r_at_start <= n_at_start;
                r_raw_left <= n_raw_left;
                r_stopped  <= n_stopped;
            end
        end
    end

endmodule

[src/cse_queue.sv]
// Short FIFO of classified words between front and back end.
`timescale 1ns / 1ps

module cse_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cse_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output cse_pkg::t_entry o_entry
);
    import cse_pkg::*;

    t_entry                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + QUEUE_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QUEUE_CNT_W'(1);
                2'b01:   r_count <= r_count - QUEUE_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[src/cse_back.sv]
// Back end: expands each classified word into output bytes, one per cycle while the output is ready.
`timescale 1ns / 1ps

module cse_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cse_pkg::t_entry i_entry,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_byte,
    output logic            o_run_last,
    output logic            o_string_end
);
    import cse_pkg::*;

    logic [2:0] r_step;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_run_last;
    logic       r_string_end;

    logic [7:0] body [4];
    logic [2:0] blen;
    logic [2:0] total;
    logic [2:0] t;
    logic [7:0] cur;
    logic       cur_last;
    logic       load;

    always_comb begin
        body[0] = CH_BACKSLASH;
        body[1] = i_entry.data;
        body[2] = hex_digit(i_entry.data[7:4]);
        body[3] = hex_digit(i_entry.data[3:0]);
        case (i_entry.kind)
            BODY_NONE: blen = 3'd0;
            BODY_RAW: begin
                blen    = 3'd1;
                body[0] = i_entry.data;
            end
            BODY_ESC: blen = 3'd2;
            BODY_HEX: begin
                blen    = 3'd4;
                body[1] = CH_X;
            end
            default: blen = 3'd0;
        endcase
    end

    assign total = {2'b00, i_entry.open_q} + blen + {2'b00, i_entry.close_q};
    assign t     = r_step - {2'b00, i_entry.open_q};

    always_comb begin
        if (i_entry.open_q && r_step == 3'd0) begin
            cur = CH_QUOTE;
        end else if (t < blen) begin
            cur = body[t[1:0]];
        end else begin
            cur = CH_QUOTE;
        end
    end

    assign cur_last = (r_step == total - 3'd1);
    assign load     = i_valid && (!r_valid || i_ready);
    assign o_pop    = load && cur_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte       <= cur;
            r_run_last   <= cur_last;
            r_string_end <= cur_last && i_entry.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_step  <= cur_last ? 3'd0 : r_step + 3'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_byte       = r_byte;
    assign o_run_last   = r_run_last;
    assign o_string_end = r_string_end;

endmodule

[src/c_string_escape_encoder_top.sv]
// Top level of the C string escape encoder.
`timescale 1ns / 1ps

// Escapes a stream of strings as C text, one input word per string byte.
// Each input word yields zero to six output bytes; the output side writes one
// byte per cycle from its output register while the sink is ready, so a plain
// printable byte passes at one word per cycle, while an escape writes 2 or 4
// bytes (plus one per quote) on the output side. A two-entry queue of
// classified words sits between the input classifier and the output expander,
// so input is taken each cycle until that queue fills. There is no startup
// sweep: the input is ready once reset has cleared the queue. The quote setting
// is sampled as each word is accepted; change it only while the block is idle.
module c_string_escape_encoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] in_byte
    input  logic [0:0] s_axis_tuser,    // [0] no_byte
    input  logic       s_axis_tlast,    // string_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] out_byte
    output logic [0:0] m_axis_tuser,    // [0] run_last
    output logic       m_axis_tlast,    // string_end
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [0:0] i_cfg_data       // [0] wrap_quotes
);
    import cse_pkg::*;

    t_entry push_entry;
    t_entry head_entry;
    logic   push;
    logic   q_full;
    logic   pop;
    logic   head_valid;

    assign o_cfg_ready = 1'b1;

    cse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .i_no_byte   (s_axis_tuser[0]),
        .i_last      (s_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data[0]),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    cse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_entry (head_entry)
    );

    cse_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (head_valid),
        .i_entry      (head_entry),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_byte       (m_axis_tdata),
        .o_run_last   (m_axis_tuser[0]),
        .o_string_end (m_axis_tlast)
    );

endmodule

[dv/c_string_escape_encoder_top_test.sv]
// Self-checking stream testbench for the C string escape encoder top level.
`timescale 1ns / 1ps

module c_string_escape_encoder_top_test;
    import cse_pkg::*;

    localparam int SETTLE_CYCLES = 12;      // idle cycles once nothing is outstanding
    localparam int MAX_REPORTS   = 10;

    localparam logic [7:0] CC_NUL = 8'h00;
    localparam logic [7:0] CC_BEL = 8'h07;
    localparam logic [7:0] CC_BS  = 8'h08;
    localparam logic [7:0] CC_HT  = 8'h09;
    localparam logic [7:0] CC_LF  = 8'h0A;
    localparam logic [7:0] CC_VT  = 8'h0B;
    localparam logic [7:0] CC_FF  = 8'h0C;
    localparam logic [7:0] CC_CR  = 8'h0D;
    localparam logic [7:0] CC_DEL = 8'h7F;

    typedef enum logic [1:0] {
        STEP_WORD,
        STEP_QUOTE_CFG,
        STEP_SETTLE
    } t_step_kind;

    typedef struct {
        t_step_kind kind;
        logic [7:0] data;
        logic       no_byte;
        logic       last;
    } t_step;

    typedef struct {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
    } t_text_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic [0:0] s_axis_tuser = 1'b0;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;
    logic       m_axis_tlast;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [0:0] i_cfg_data = 1'b0;

    c_string_escape_encoder_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic       quote_on = 1'b1;
    logic       at_start = 1'b1;
    logic [1:0] raw_left = 2'd0;
    logic       nul_stop = 1'b0;

    t_step      pending[$];
    t_text_byte expected_text[$];
    int         word_total = 0;
    int         err_count = 0;
    logic       all_sent = 1'b0;

    // driver and sink bookkeeping
    t_step step;
    logic  word_taken, cfg_taken, next_valid, next_cfg;
    int    gap_left = 0;
    int    settle_cnt = 0;
    int    stall_left = 0;
    logic  src_calm = 1'b0;
    logic  snk_calm = 1'b0;

    function automatic int pick_gap(input logic calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + {4'h0, v};
        return 8'h41 + {4'h0, v} - 8'd10;
    endfunction

    // letter of the two-character escape, zero when the byte takes \xHH
    function automatic logic [7:0] escape_letter(input logic [7:0] b);
        case (b)
            CH_BACKSLASH: return CH_BACKSLASH;
            CH_QUOTE:     return CH_QUOTE;
            CC_BEL:       return "a";
            CC_BS:        return "b";
            CC_HT:        return "t";
            CC_LF:        return "n";
            CC_VT:        return "v";
            CC_FF:        return "f";
            CC_CR:        return "r";
            default:      return 8'h00;
        endcase
    endfunction

    task automatic predict_escape(input logic [7:0] b, input logic nb, input logic last);
        logic [7:0] text[$];
        logic [7:0] letter;
        t_text_byte tb;
        if (at_start) begin
            if (quote_on) text.push_back(CH_QUOTE);
            at_start = 1'b0;
        end
        if (!nb && !nul_stop) begin
            if (raw_left != 2'd0) begin
                text.push_back(b);
                raw_left = raw_left - 2'd1;
            end else if (b[7:5] == 3'b110) begin
                text.push_back(b);
                raw_left = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                text.push_back(b);
                raw_left = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                text.push_back(b);
                raw_left = 2'd3;
            end else if (b >= CH_SPACE && b <= CH_TILDE && b != CH_QUOTE
                         && b != CH_BACKSLASH) begin
                text.push_back(b);
            end else begin
                letter = escape_letter(b);
                text.push_back(CH_BACKSLASH);
                if (letter != 8'h00) begin
                    text.push_back(letter);
                end else begin
                    text.push_back(CH_X);
                    text.push_back(nibble_char(b[7:4]));
                    text.push_back(nibble_char(b[3:0]));
                end
                if (b == CC_NUL) nul_stop = 1'b1;
            end
        end
        if (last) begin
            if (quote_on) text.push_back(CH_QUOTE);
            at_start = 1'b1;
            raw_left = 2'd0;
            nul_stop = 1'b0;
        end
        foreach (text[k]) begin
            tb.out_byte   = text[k];
            tb.run_last   = (k == text.size() - 1);
            tb.string_end = (k == text.size() - 1) && last;
            expected_text.push_back(tb);
        end
    endtask

    task automatic check_text_byte(input logic [7:0] d, input logic rl, input logic se);
        t_text_byte want;
        if (expected_text.size() == 0) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("unexpected word: byte %h run_last %b string_end %b", d, rl, se);
        end else begin
            want = expected_text.pop_front();
            if (want.out_byte !== d || want.run_last !== rl || want.string_end !== se) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("mismatch: expected byte %h run_last %b string_end %b, got %h %b %b",
                             want.out_byte, want.run_last, want.string_end, d, rl, se);
            end
        end
    endtask

    task automatic add_word(input logic [7:0] d, input logic nb, input logic last);
        t_step s;
        s.kind = STEP_WORD;
        s.data = d;
        s.no_byte = nb;
        s.last = last;
        pending.push_back(s);
        word_total++;
    endtask

    task automatic add_settle();
        t_step s;
        s.kind = STEP_SETTLE;
        s.data = 8'h00;
        s.no_byte = 1'b0;
        s.last = 1'b0;
        pending.push_back(s);
    endtask

    task automatic add_quote_cfg(input logic q);
        t_step s;
        add_settle();
        s.kind = STEP_QUOTE_CFG;
        s.data = {7'd0, q};
        s.no_byte = 1'b0;
        s.last = 1'b0;
        pending.push_back(s);
    endtask

    // mostly well-formed text with UTF-8 runs, escapes, NULs and empty words mixed in
    task automatic add_random_string();
        t_step s[$];
        t_step w;
        int n, cat, cont;
        logic [7:0] specials[9];
        specials = '{CH_QUOTE, CH_BACKSLASH, CC_BEL, CC_BS, CC_HT, CC_LF, CC_VT, CC_FF, CC_CR};
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 6);
        w.kind = STEP_WORD;
        w.last = 1'b0;
        w.no_byte = 1'b0;
        while (s.size() < n) begin
            cat = $urandom_range(0, 99);
            w.no_byte = 1'b0;
            if (cat < 38) begin
                w.data = 8'($urandom_range(8'h20, 8'h7E));
                s.push_back(w);
            end else if (cat < 50) begin
                w.data = specials[$urandom_range(0, 8)];
                s.push_back(w);
            end else if (cat < 60) begin
                w.data = 8'($urandom_range(0, 255));
                s.push_back(w);
            end else if (cat < 82) begin
                cont = $urandom_range(1, 3);
                w.data = 8'($urandom_range(0, 255));
                if (cont == 1) w.data[7:5] = 3'b110;
                else if (cont == 2) w.data[7:4] = 4'b1110;
                else w.data[7:3] = 5'b11110;
                s.push_back(w);
                repeat (cont) begin
                    w.data = {2'b10, 6'($urandom_range(0, 63))};
                    s.push_back(w);
                end
            end else if (cat < 87) begin
                w.data = CC_NUL;
                s.push_back(w);
            end else begin
                w.data = 8'($urandom_range(0, 255));
                w.no_byte = 1'b1;
                s.push_back(w);
            end
        end
        if ($urandom_range(0, 19) == 0) begin
            s.delete();
            w.data = 8'($urandom_range(0, 255));
            w.no_byte = 1'b1;
            s.push_back(w);
        end
        s[s.size() - 1].last = 1'b1;
        foreach (s[k]) add_word(s[k].data, s[k].no_byte, s[k].last);
    endtask

    // source side: one word per handshake, config writes only when drained
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            word_taken = s_axis_tvalid && s_axis_tready;
            cfg_taken  = i_cfg_valid && o_cfg_ready;
            if (word_taken) begin
                predict_escape(s_axis_tdata, s_axis_tuser[0], s_axis_tlast);
                if ($urandom_range(0, 59) == 0) src_calm = !src_calm;
            end
            if (cfg_taken) quote_on = i_cfg_data[0];
            if (!((s_axis_tvalid && !word_taken) || (i_cfg_valid && !cfg_taken))) begin
                next_valid = 1'b0;
                next_cfg   = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending.size() == 0) begin
                    all_sent = 1'b1;
                end else begin
                    case (pending[0].kind)
                        STEP_WORD: begin
                            step = pending.pop_front();
                            s_axis_tdata <= step.data;
                            s_axis_tuser <= step.no_byte;
                            s_axis_tlast <= step.last;
                            next_valid = 1'b1;
                            gap_left = pick_gap(src_calm);
                        end
                        STEP_QUOTE_CFG: begin
                            step = pending.pop_front();
                            i_cfg_data <= step.data[0];
                            next_cfg = 1'b1;
                        end
                        default: begin
                            // hold off until everything has drained out
                            if (expected_text.size() != 0) begin
                                settle_cnt = 0;
                            end else if (settle_cnt >= SETTLE_CYCLES) begin
                                step = pending.pop_front();
                                settle_cnt = 0;
                            end else begin
                                settle_cnt++;
                            end
                        end
                    endcase
                end
                s_axis_tvalid <= next_valid;
                i_cfg_valid   <= next_cfg;
            end
        end
    end

    // sink side: random backpressure, check each word against the prediction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_text_byte(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
                if ($urandom_range(0, 79) == 0) snk_calm = !snk_calm;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap(snk_calm);
            end
        end
    end

    initial begin
        int base;
        // quotes on, as after reset
        add_word(CH_SPACE, 1'b0, 1'b0);
        add_word(8'h41, 1'b0, 1'b0);
        add_word(CH_TILDE, 1'b0, 1'b0);
        add_word(CH_QUOTE, 1'b0, 1'b0);
        add_word(CH_BACKSLASH, 1'b0, 1'b1);
        add_word(CC_BEL, 1'b0, 1'b0);
        add_word(CC_BS, 1'b0, 1'b0);
        add_word(CC_HT, 1'b0, 1'b0);
        add_word(CC_LF, 1'b0, 1'b0);
        add_word(CC_VT, 1'b0, 1'b0);
        add_word(CC_FF, 1'b0, 1'b0);
        add_word(CC_CR, 1'b0, 1'b1);
        // stray continuation, DEL and 0xFF as hex escapes
        add_word(8'h1F, 1'b0, 1'b0);
        add_word(8'h80, 1'b0, 1'b0);
        add_word(CC_DEL, 1'b0, 1'b0);
        add_word(8'hFF, 1'b0, 1'b1);
        add_word(8'hA5, 1'b1, 1'b1);            // empty string
        add_word(8'hF0, 1'b0, 1'b0);
        add_word(8'h9F, 1'b0, 1'b0);
        add_word(8'h98, 1'b0, 1'b0);
        add_word(8'h80, 1'b0, 1'b0);
        add_word(8'hE2, 1'b0, 1'b0);
        add_word(8'h82, 1'b0, 1'b1);            // string end cuts the raw copy
        add_quote_cfg(1'b0);
        // NUL then ignored bytes, last word yields nothing: no end mark
        add_word(CC_NUL, 1'b0, 1'b0);
        add_word(8'h41, 1'b0, 1'b0);
        add_word(8'hF8, 1'b0, 1'b1);
        add_word(8'h5A, 1'b1, 1'b1);

        add_quote_cfg(1'b1);
        base = word_total;
        while (word_total < base + 135) add_random_string();
        add_settle();
        add_quote_cfg(1'b0);
        while (word_total < base + 270) add_random_string();
        add_quote_cfg(1'b1);
        while (word_total < base + 400) add_random_string();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(all_sent && expected_text.size() == 0)) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0 && expected_text.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
src/cse_pkg.sv
src/cse_front.sv
src/cse_queue.sv
src/cse_back.sv
src/c_string_escape_encoder_top.sv
dv/c_string_escape_encoder_top_test.sv
